### rtl/core/integer_to_ascii_radix_macros.svh
// Assertion macros shared by the conversion block.
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ITOAR_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ITOAR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### rtl/core/itoar_pkg.sv
package itoar_pkg;

   localparam int VALUE_BITS     = 32;
   localparam int RADIX_W        = 6;
   localparam int DIGIT_W        = 6;
   localparam int CHAR_W         = 8;
   localparam int IDX_W          = $clog2(VALUE_BITS);
   localparam int BITS_PER_CYCLE = 8;
   localparam int DIV_STEPS      = VALUE_BITS / BITS_PER_CYCLE;
   localparam int STEP_W         = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);

   localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] ASCII_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] ASCII_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] DIGIT_TEN     = 8'd10;

   typedef struct packed {
      logic                  req_type;
      logic [VALUE_BITS-1:0] number;
      logic [RADIX_W-1:0]    radix;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last_char;
      logic              bad_radix;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_READ,
      ST_PUT,
      ST_ERROR
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic sign_put;
      logic read;
      logic char_put;
      logic err_put;
   } itoar_cmd_type;

   typedef struct packed {
      logic bad_radix;
      logic div_done;
      logic negative;
      logic out_free;
      logic last_ptr;
   } itoar_sts_type;

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] wide;
      wide = CHAR_W'(d);
      if (wide < DIGIT_TEN) begin
         return ASCII_ZERO + wide;
      end
      return ASCII_UPPER_A + wide - DIGIT_TEN;
   endfunction

endpackage

### rtl/core/itoar_ctrl.sv
module itoar_ctrl
   import itoar_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  itoar_sts_type sts,
   output itoar_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = sts.bad_radix ? ST_ERROR : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (sts.div_done) begin
               state_in = sts.negative ? ST_SIGN : ST_READ;
            end
         end
         ST_SIGN: begin
            if (sts.out_free) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_PUT;
         end
         ST_PUT: begin
            if (sts.out_free) begin
               state_in = sts.last_ptr ? ST_IDLE : ST_READ;
            end
         end
         ST_ERROR: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall    = 1'b1;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_SIGN: begin
            cmd.sign_put = sts.out_free;
         end
         ST_READ: begin
            cmd.read = 1'b1;
         end
         ST_PUT: begin
            cmd.char_put = sts.out_free;
         end
         ST_ERROR: begin
            cmd.err_put = sts.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

### rtl/core/itoar_dp.sv
`include "integer_to_ascii_radix_macros.svh"

module itoar_dp
   import itoar_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_data,
   input  itoar_cmd_type   cmd,
   output itoar_sts_type   sts,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   logic [DIGIT_W-1:0] store_mem [VALUE_BITS];

   logic [RADIX_W-1:0]    radix_ff, radix_in;
   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic [DIGIT_W-1:0]    rem_ff, rem_in;
   logic                  neg_ff, neg_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      ptr_ff, ptr_in;
   logic [DIGIT_W-1:0]    rd_digit_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic                  req_bad;
   logic                  req_neg;
   logic [VALUE_BITS-1:0] quot_next;
   logic [DIGIT_W-1:0]    rem_next;
   logic                  last_step;
   logic                  quot_zero;
   logic                  out_free;
   logic                  any_put;
   logic                  radix_ok;
   logic                  err_marked;

   assign req_bad   = (req_data.radix < RADIX_MIN) || (req_data.radix > RADIX_MAX);
   assign req_neg   = req_data.req_type && (req_data.radix == RADIX_DEC)
                      && req_data.number[VALUE_BITS-1];
   assign last_step = (step_ff == STEP_W'(DIV_STEPS - 1));
   assign quot_zero = (quot_next == '0);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Restoring division, BITS_PER_CYCLE quotient bits per cycle.
   always_comb begin
      logic [DIGIT_W:0]      trial;
      logic [DIGIT_W-1:0]    r;
      logic [VALUE_BITS-1:0] q;
      r = rem_ff;
      q = quot_ff;
      for (int i = 0; i < BITS_PER_CYCLE; i++) begin
         trial = {r, q[VALUE_BITS-1]};
         q     = {q[VALUE_BITS-2:0], 1'b0};
         if (trial >= {1'b0, radix_ff}) begin
            r    = DIGIT_W'(trial - {1'b0, radix_ff});
            q[0] = 1'b1;
         end else begin
            r = trial[DIGIT_W-1:0];
         end
      end
      quot_next = q;
      rem_next  = r;
   end

   always_comb begin
      radix_in = radix_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      step_in  = step_ff;
      idx_in   = idx_ff;
      ptr_in   = ptr_ff;
      if (cmd.load) begin
         radix_in = req_data.radix;
         quot_in  = req_neg ? (VALUE_BITS'(0) - req_data.number) : req_data.number;
         rem_in   = '0;
         neg_in   = req_neg;
         step_in  = '0;
         idx_in   = '0;
      end else if (cmd.div_step) begin
         quot_in = quot_next;
         if (last_step) begin
            rem_in  = '0;
            step_in = '0;
            if (quot_zero) begin
               ptr_in = idx_ff;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end else begin
            rem_in  = rem_next;
            step_in = step_ff + STEP_W'(1);
         end
      end else if (cmd.char_put && (ptr_ff != '0)) begin
         ptr_in = ptr_ff - IDX_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.err_put) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.character = ASCII_NUL;
         rsp_data_in.last_char = 1'b1;
         rsp_data_in.bad_radix = 1'b1;
      end else if (cmd.sign_put) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.character = ASCII_MINUS;
         rsp_data_in.last_char = 1'b0;
         rsp_data_in.bad_radix = 1'b0;
      end else if (cmd.char_put) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.character = digit_to_ascii(rd_digit_ff);
         rsp_data_in.last_char = (ptr_ff == '0);
         rsp_data_in.bad_radix = 1'b0;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      radix_ff    <= radix_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      idx_ff      <= idx_in;
      ptr_ff      <= ptr_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.div_step && last_step) begin
         store_mem[idx_ff] <= rem_next;
      end
      if (cmd.read) begin
         rd_digit_ff <= store_mem[ptr_ff];
      end
   end

   assign sts.bad_radix = req_bad;
   assign sts.div_done  = cmd.div_step && last_step && quot_zero;
   assign sts.negative  = neg_ff;
   assign sts.out_free  = out_free;
   assign sts.last_ptr  = (ptr_ff == '0);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign any_put    = cmd.sign_put || cmd.char_put || cmd.err_put;
   assign radix_ok   = (radix_ff >= RADIX_MIN) && (radix_ff <= RADIX_MAX);
   assign err_marked = rsp_valid_ff && rsp_data_ff.bad_radix && rsp_data_ff.last_char;

   `ITOAR_ASSERT_IMPL(put_only_when_free, clock, reset, any_put, out_free)
   `ITOAR_ASSERT_IMPL(rem_below_radix, clock, reset, cmd.div_step, rem_ff < radix_ff)
   `ITOAR_ASSERT_IMPL(divide_radix_valid, clock, reset, cmd.div_step, radix_ok)
   `ITOAR_ASSERT_NEXT(error_result_marked, clock, reset, cmd.err_put, err_marked)

endmodule

### rtl/core/integer_to_ascii_radix.sv
// Converts one value per transaction, most significant digit first; '-' leads a negative signed decimal value.
// All digits are first divided out by the 8-bit-per-cycle divider, one full division per digit;
// each is then read from the digit store (READ state) and put out when the output is free (PUT state).
// A new transaction is accepted only after the last character of the previous one has been put out.
// A bad radix puts out a single NUL character marked last and bad radix once the output is free, then returns to idle.
// Synchronous reset clears the controller and the output valid; the digit store is not cleared.
module integer_to_ascii_radix
   import itoar_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   itoar_cmd_type cmd;
   itoar_sts_type sts;

   itoar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   itoar_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
